// ===== rtl/sxr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxr_pkg
// Shared types and constants for the xorshift generator with range reduction.
// ----------------------------------------------------------------------------
package sxr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned SHIFT_T    = 8;
    localparam int unsigned SHIFT_ONE  = 1;
    localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(WORD_W - 1);

    // request codes
    localparam logic FUNC_RAW   = 1'b0;
    localparam logic FUNC_RANGE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
    } t_stat;

endpackage

// ===== rtl/sxr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxr_ctrl
// Sequencer: accepts a word, runs the divider steps, hands off the result.
// ----------------------------------------------------------------------------
module sxr_ctrl import sxr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;
    logic               w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.need_div || r_count == LAST_STEP) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and step counter
    always_comb begin
        o_cmd       = '0;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                o_cmd.start = w_accept;
                n_count     = '0;
            end
            S_DIV: begin
                if (i_stat.need_div) begin
                    o_cmd.div_step = 1'b1;
                    n_count        = r_count + COUNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/sxr_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxr_dpath
// Generator words, bit-serial remainder unit and output word register.
// ----------------------------------------------------------------------------
module sxr_dpath import sxr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_range_low,
    input  logic [WORD_W-1:0] i_range_high,
    output t_stat             o_stat,
    output logic [WORD_W-1:0] o_random_value
);

    logic [WORD_W-1:0] r_w0, r_w1, r_w2, r_w3;
    logic [WORD_W-1:0] w_t, w_new;
    logic              r_func;
    logic [WORD_W-1:0] r_low, r_span, r_word, r_dividend, r_rem, r_out;
    logic [WORD_W:0]   w_trial;
    logic [WORD_W:0]   w_diff;
    logic [WORD_W-1:0] w_result;

    // generator advance
    assign w_t   = r_w0 ^ (r_w0 << SHIFT_T);
    assign w_new = r_w3 ^ w_t ^ (r_w3 >> SHIFT_ONE) ^ (w_t << SHIFT_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
            r_w3 <= WORD_W'(1);
        end else if (i_cmd.start) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= r_w3;
            r_w3 <= w_new;
        end
    end

    // restoring remainder step
    assign w_trial = {r_rem, r_dividend[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_span};

    // request capture and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func     <= i_func;
            r_low      <= i_range_low;
            r_span     <= i_range_high - i_range_low + WORD_W'(1);
            r_word     <= w_new;
            r_dividend <= w_new;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= w_diff[WORD_W] ? w_trial[WORD_W-1:0] : w_diff[WORD_W-1:0];
        end
    end

    assign o_stat.need_div = (r_func == FUNC_RANGE) && (r_span != '0);

    // final word select
    always_comb begin
        if (r_func == FUNC_RAW) begin
            w_result = r_word;
        end else if (r_span == '0) begin
            w_result = r_low + r_word;
        end else begin
            w_result = r_low + r_rem;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= w_result;
        end
    end

    assign o_random_value = r_out;

endmodule

// ===== rtl/shift_xor_random_in_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_xor_random_in_range
// Four-word xorshift generator returning a raw word or a value in a range.
// ----------------------------------------------------------------------------
// flow: accept in S_IDLE, reduce in S_DIV, hand off in S_DONE (held while
//   the output stalls); no new word is taken before that, and only range
//   requests of nonzero span run the 32 one-bit-per-cycle remainder steps
// reset: synchronous active low; generator words go to 0,0,0,1 and no word
//   is pending at the output
module shift_xor_random_in_range import sxr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_range_low,
    input  logic [WORD_W-1:0] i_range_high,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_random_value
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    sxr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // generator and remainder datapath
    sxr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_func         (i_func),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_stat         (w_stat),
        .o_random_value (o_random_value)
    );

endmodule

// ===== test/tb_shift_xor_random_in_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shift_xor_random_in_range
// Checks the xorshift generator with range reduction against a local model
// of the four generator words. A short table of requests covers the reset
// sequence, span-of-one, full-range and inverted bounds; random requests
// follow under bursty input and a stalling output, including one long output
// hold-off and one input pause until every word due has come back.
// ----------------------------------------------------------------------------
module tb_shift_xor_random_in_range;
    import sxr_pkg::*;

    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned DIR_ROWS     = 20;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned PAUSE_AT     = 500;

    typedef struct {
        logic              func;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        bit                pinned;
        logic [WORD_W-1:0] value;
    } t_dir_row;

    typedef struct {
        bit                pinned;
        logic [WORD_W-1:0] value;
    } t_pin;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_func;
    logic [WORD_W-1:0] i_range_low;
    logic [WORD_W-1:0] i_range_high;
    logic              o_valid;
    logic              i_ready;
    logic [WORD_W-1:0] o_random_value;

    // generator words of the local model, reset values
    logic [WORD_W-1:0] gen_oldest = '0;
    logic [WORD_W-1:0] gen_second = '0;
    logic [WORD_W-1:0] gen_third  = '0;
    logic [WORD_W-1:0] gen_newest = 32'd1;

    logic [WORD_W-1:0] draws_due [$];
    t_pin              pins_sent [$];
    int                errors      = 0;
    int                results_got = 0;

    // directed requests; values typed in only where obvious from the reset state
    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{FUNC_RAW,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{FUNC_RANGE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_RANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{FUNC_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_RANGE, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{FUNC_RAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h0000_000A, 32'h0000_0005, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'hFFFF_FFF0, 32'h0000_000F, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h1234_5678, 32'h1234_5678, 1'b1, 32'h1234_5678},
        '{FUNC_RANGE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{FUNC_RAW,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'd1000,      32'd1999,      1'b0, 32'h0},
        '{FUNC_RANGE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
        '{FUNC_RAW,   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{FUNC_RANGE, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0}
    };

    shift_xor_random_in_range dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_shift_xor_random_in_range: done, errors");
        $finish;
    end

    // advance the model once and reduce the new word as requested
    function automatic logic [WORD_W-1:0] xorshift_draw(input logic f,
                                                        input logic [WORD_W-1:0] lo,
                                                        input logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] span;
        t          = gen_oldest ^ (gen_oldest << SHIFT_T);
        gen_oldest = gen_second;
        gen_second = gen_third;
        gen_third  = gen_newest;
        gen_newest = gen_third ^ t ^ (gen_third >> SHIFT_ONE) ^ (t << SHIFT_ONE);
        if (f == FUNC_RAW)
            return gen_newest;
        span = hi - lo + 32'd1;
        // full range: span wrapped to zero, no reduction
        if (span == '0)
            return lo + gen_newest;
        return lo + gen_newest % span;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    // present one request word and hold it until accepted
    task automatic offer_word(input logic f, input logic [WORD_W-1:0] lo,
                              input logic [WORD_W-1:0] hi, input bit pinned,
                              input logic [WORD_W-1:0] value);
        t_pin p;
        p.pinned = pinned;
        p.value  = value;
        @(negedge i_clk);
        pins_sent.push_back(p);
        i_valid      = 1'b1;
        i_func       = f;
        i_range_low  = lo;
        i_range_high = hi;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid when n is positive; n sets how long it stays low
    task automatic hold_input(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // accepted requests feed the model, accepted results are checked
    always @(posedge i_clk) begin : watch
        t_pin              p;
        logic [WORD_W-1:0] model_value;
        logic [WORD_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                p           = pins_sent.pop_front();
                model_value = xorshift_draw(i_func, i_range_low, i_range_high);
                draws_due.push_back(p.pinned ? p.value : model_value);
            end
            if (o_valid && i_ready) begin
                results_got++;
                if (draws_due.size() == 0) begin
                    report_mismatch("word with nothing due", '0, o_random_value);
                end else begin
                    want = draws_due.pop_front();
                    if (o_random_value !== want)
                        report_mismatch("random_value", want, o_random_value);
                end
            end
        end
    end

    // output side: stall patterns in phases, one long hold-off
    initial begin : receiver
        int          mode;
        int          phase_len;
        int          ph;
        bit          hold_done;
        logic [7:0]  pat;
        hold_done = 1'b0;
        ph        = 0;
        i_ready   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode      = $urandom_range(0, 3);
            phase_len = $urandom_range(5, 60);
            pat       = 8'($urandom);
            repeat (phase_len) begin
                @(negedge i_clk);
                if (!hold_done && results_got >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    i_ready   = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0: i_ready = 1'b1;
                    1: i_ready = 1'($urandom_range(0, 1));
                    2: i_ready = ($urandom_range(0, 7) == 0);
                    default: begin
                        i_ready = pat[ph[2:0]];
                        ph++;
                    end
                endcase
            end
        end
    end

    // input side: reset, directed table, random requests, drain
    initial begin : sender
        int                burst_left;
        int                kind;
        logic              f;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FUNC_RAW;
        i_range_low  = '0;
        i_range_high = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            hold_input($urandom_range(0, 3));
            offer_word(dir_rows[r].func, dir_rows[r].lo, dir_rows[r].hi,
                       dir_rows[r].pinned, dir_rows[r].value);
        end

        // random requests in bursts
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == PAUSE_AT) begin
                // stop offering until every word due is back
                @(negedge i_clk);
                i_valid = 1'b0;
                while (draws_due.size() != 0) @(posedge i_clk);
            end else if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                hold_input($urandom_range(0, 8));
            end
            burst_left--;

            f    = ($urandom_range(0, 9) < 4) ? FUNC_RAW : FUNC_RANGE;
            lo   = $urandom;
            hi   = $urandom;
            kind = $urandom_range(0, 9);
            case (kind)
                0: hi = lo - 32'd1;                      // full range
                1: hi = lo;                              // span of one
                2, 3, 4: hi = lo + $urandom_range(0, 255);
                5: lo = '0;
                6: hi = lo + ($urandom & 32'h0000_FFFF);
                default: ;                               // any bounds, often inverted
            endcase
            offer_word(f, lo, hi, 1'b0, '0);
        end

        // drain
        @(negedge i_clk);
        i_valid = 1'b0;
        while (draws_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_shift_xor_random_in_range: done, clean");
        end else begin
            $display("tb_shift_xor_random_in_range: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sxr_pkg.sv
rtl/sxr_ctrl.sv
rtl/sxr_dpath.sv
rtl/shift_xor_random_in_range.sv
test/tb_shift_xor_random_in_range.sv
